FILE: rtl/srtn_pkg.sv
package srtn_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 64;

   // input function codes
   localparam logic [1:0] FUNC_ARRIVE = 2'd0;
   localparam logic [1:0] FUNC_FINISH = 2'd1;
   localparam logic [1:0] FUNC_SRC_DONE = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_DISPATCH = 3'd0;
   localparam logic [2:0] KIND_PREEMPT = 3'd1;
   localparam logic [2:0] KIND_IDLE = 3'd2;
   localparam logic [2:0] KIND_ALL_DONE = 3'd3;
   localparam logic [2:0] KIND_DROPPED = 3'd4;

   typedef struct packed {
      logic [1:0] func;
      logic [31:0] now;
      logic [15:0] job_id;
      logic [15:0] job_time;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [15:0] out_job_id;
      logic [15:0] out_job_time;
      logic last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_CHECK,
      S_PREEMPT,
      S_DISPATCH,
      S_REQUEUE,
      S_FINISH,
      S_DROP
   } state_type;

   typedef enum logic [1:0] {
      SRC_HEAD,
      SRC_RUN,
      SRC_REQ,
      SRC_ZERO
   } emit_src_type;

   typedef struct packed {
      logic load_req;
      logic insert;
      logic ins_hold;
      logic pop;
      logic charge;
      logic save_hold;
      logic stop_running;
      logic set_done;
      logic emit;
      logic [2:0] emit_kind;
      emit_src_type emit_src;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic running_valid;
      logic head_lt_run;
      logic source_done;
   } status_type;

endpackage

FILE: rtl/srtn_preemptive_scheduler_core.sv
// shortest-remaining-time-next scheduler core
// input: pulse start with req_data while busy is low; the item transfers at
//   that edge. func selects arrival, finish of the running job or source done.
// output: each result shows on rsp_data for one cycle with rsp_strobe high;
//   rsp_data.last marks the final result of an item. The receiver cannot
//   stall, so results are never held back.
// waiting jobs sit in a chain of cells kept sorted by remaining time, earlier
//   insert first on ties; the head is always the next job to run.
// steps per item (busy high while they run):
//   source done none, dropped arrival drop, finish then dispatch if jobs wait,
//   arrival with nothing running insert and dispatch, arrival that keeps the
//   runner insert and check, arrival that preempts insert, check, preempt, dispatch and requeue.
// results appear in the cycle after the state that makes them, through the
//   result register; the rate is set by the sequencer walking these steps
//   over the single insert/shift port of the cell chain.
// reset clears the job count, the running job and the source done flag;
//   cell contents need no clearing.
module srtn_preemptive_scheduler_core
   import srtn_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type cmd;
   status_type status;

   srtn_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .func(req_data.func),
      .status(status),
      .cmd(cmd),
      .busy(busy)
   );

   srtn_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .cmd(cmd),
      .status(status),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // never insert into a full chain
   assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !status.full)
      else $error("insert into full queue");

   // never dispatch from an empty chain
   assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !status.empty)
      else $error("dispatch from empty queue");

   // a dispatch leaves a job running
   assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> status.running_valid)
      else $error("dispatch left nothing running");

   // results come only from work in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without work");

endmodule

FILE: rtl/srtn_ctrl.sv
module srtn_ctrl
   import srtn_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [1:0] func,
   input  status_type status,
   output cmd_type cmd,
   output logic busy
);

   state_type state_ff, state_in;
   logic requeue_ff, requeue_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         requeue_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         requeue_ff <= requeue_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      requeue_in = requeue_ff;
      cmd = '0;
      cmd.emit_src = SRC_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            requeue_in = 1'b0;
            if (start) begin
               cmd.load_req = 1'b1;
               unique case (func)
                  FUNC_ARRIVE: state_in = status.full ? S_DROP : S_INSERT;
                  FUNC_FINISH: state_in = S_FINISH;
                  FUNC_SRC_DONE: cmd.set_done = 1'b1;
                  default: ;
               endcase
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            cmd.charge = status.running_valid;
            state_in = status.running_valid ? S_CHECK : S_DISPATCH;
         end
         S_CHECK: begin
            state_in = status.head_lt_run ? S_PREEMPT : S_IDLE;
         end
         S_PREEMPT: begin
            cmd.emit = 1'b1;
            cmd.emit_kind = KIND_PREEMPT;
            cmd.emit_src = SRC_RUN;
            cmd.save_hold = 1'b1;
            requeue_in = 1'b1;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            cmd.emit = 1'b1;
            cmd.emit_kind = KIND_DISPATCH;
            cmd.emit_src = SRC_HEAD;
            cmd.emit_last = 1'b1;
            cmd.pop = 1'b1;
            state_in = requeue_ff ? S_REQUEUE : S_IDLE;
         end
         S_REQUEUE: begin
            cmd.insert = 1'b1;
            cmd.ins_hold = 1'b1;
            state_in = S_IDLE;
         end
         S_FINISH: begin
            cmd.stop_running = 1'b1;
            if (status.empty) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = status.source_done ? KIND_ALL_DONE : KIND_IDLE;
               cmd.emit_last = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DISPATCH;
            end
         end
         S_DROP: begin
            cmd.emit = 1'b1;
            cmd.emit_kind = KIND_DROPPED;
            cmd.emit_src = SRC_REQ;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: rtl/srtn_datapath.sv
module srtn_datapath
   import srtn_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output status_type status,
   output logic rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // sorted cell chain: ascending time, earlier insert first on ties
   logic [15:0] ids_ff [QUEUE_DEPTH];
   logic [15:0] times_ff [QUEUE_DEPTH];
   logic [15:0] ids_in [QUEUE_DEPTH];
   logic [15:0] times_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] le;
   logic [CW-1:0] count_ff, count_in;

   req_type req_ff;
   logic run_valid_ff, run_valid_in;
   logic [15:0] run_id_ff, run_id_in;
   logic [15:0] run_left_ff, run_left_in;
   logic [31:0] charged_ff, charged_in;
   logic done_ff, done_in;
   logic [15:0] hold_id_ff, hold_time_ff;
   logic rsp_strobe_ff;
   rsp_type rsp_ff, rsp_in;

   logic [15:0] ins_id, ins_time;
   logic [31:0] elapsed;
   logic [15:0] charged_left;

   assign ins_id = cmd.ins_hold ? hold_id_ff : req_ff.job_id;
   assign ins_time = cmd.ins_hold ? hold_time_ff : req_ff.job_time;

   // per cell compare against the inserted key
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         le[i] = (CW'(i) < count_ff) && (times_ff[i] <= ins_time);
      end
   end

   // per cell next value
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [15:0] prev_id, prev_time, next_id, next_time;
      logic prev_le;
      if (g == 0) begin : g_first
         assign prev_id = ins_id;
         assign prev_time = ins_time;
         assign prev_le = 1'b1;
      end else begin : g_rest
         assign prev_id = ids_ff[g-1];
         assign prev_time = times_ff[g-1];
         assign prev_le = le[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign next_id = ids_ff[g];
         assign next_time = times_ff[g];
      end else begin : g_mid
         assign next_id = ids_ff[g+1];
         assign next_time = times_ff[g+1];
      end
      always_comb begin
         ids_in[g] = ids_ff[g];
         times_in[g] = times_ff[g];
         if (cmd.insert && !le[g]) begin
            if (prev_le) begin
               ids_in[g] = ins_id;
               times_in[g] = ins_time;
            end else begin
               ids_in[g] = prev_id;
               times_in[g] = prev_time;
            end
         end else if (cmd.pop) begin
            ids_in[g] = next_id;
            times_in[g] = next_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ids_ff[i] <= ids_in[i];
         times_ff[i] <= times_in[i];
      end
   end

   // charge running job, saturating at zero
   assign elapsed = req_ff.now - charged_ff;
   assign charged_left = (elapsed >= {16'd0, run_left_ff}) ? 16'd0
                         : run_left_ff - elapsed[15:0];

   // control registers
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
      run_valid_in = run_valid_ff;
      run_id_in = run_id_ff;
      run_left_in = run_left_ff;
      charged_in = charged_ff;
      if (cmd.stop_running) begin
         run_valid_in = 1'b0;
      end
      if (cmd.charge) begin
         run_left_in = charged_left;
         charged_in = req_ff.now;
      end
      if (cmd.pop) begin
         run_valid_in = 1'b1;
         run_id_in = ids_ff[0];
         run_left_in = times_ff[0];
         charged_in = req_ff.now;
      end
      done_in = done_ff | cmd.set_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         run_valid_ff <= 1'b0;
         run_id_ff <= '0;
         run_left_ff <= '0;
         charged_ff <= '0;
         done_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         run_valid_ff <= run_valid_in;
         run_id_ff <= run_id_in;
         run_left_ff <= run_left_in;
         charged_ff <= charged_in;
         done_ff <= done_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   // request and hold registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.save_hold) begin
         hold_id_ff <= run_id_ff;
         hold_time_ff <= run_left_ff;
      end
   end

   // result register
   always_comb begin
      rsp_in.kind = cmd.emit_kind;
      rsp_in.last = cmd.emit_last;
      case (cmd.emit_src)
         SRC_HEAD: begin
            rsp_in.out_job_id = ids_ff[0];
            rsp_in.out_job_time = times_ff[0];
         end
         SRC_RUN: begin
            rsp_in.out_job_id = run_id_ff;
            rsp_in.out_job_time = run_left_ff;
         end
         SRC_REQ: begin
            rsp_in.out_job_id = req_ff.job_id;
            rsp_in.out_job_time = req_ff.job_time;
         end
         default: begin
            rsp_in.out_job_id = '0;
            rsp_in.out_job_time = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

   assign status.full = (count_ff == CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.running_valid = run_valid_ff;
   assign status.head_lt_run = times_ff[0] < run_left_ff;
   assign status.source_done = done_ff;

endmodule

FILE: sim/srtn_preemptive_scheduler_core_tb.sv
`timescale 1ns / 1ps

module srtn_preemptive_scheduler_core_tb
   import srtn_pkg::*;
();

   localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;

   srtn_preemptive_scheduler_core #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // scheduler image kept by the testbench
   logic [15:0] wait_ids[$];
   logic [15:0] wait_times[$];
   logic run_valid;
   logic [15:0] run_id;
   logic [15:0] run_left;
   logic [31:0] last_charge;
   logic gen_done;

   rsp_type sched_events[$];
   int mismatches;
   int results_seen;
   int drops_seen;
   int preempts_seen;
   longint cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type make_event(logic [2:0] k, logic [15:0] id,
                                          logic [15:0] t);
      rsp_type r;
      r.kind = k;
      r.out_job_id = id;
      r.out_job_time = t;
      r.last = 1'b0;
      return r;
   endfunction

   // remove the shortest waiting job, earliest on ties, and run it
   function automatic rsp_type run_shortest(logic [31:0] now);
      int best;
      best = 0;
      for (int i = 1; i < wait_times.size(); i++)
         if (wait_times[i] < wait_times[best]) best = i;
      run_id = wait_ids[best];
      run_left = wait_times[best];
      wait_ids.delete(best);
      wait_times.delete(best);
      run_valid = 1'b1;
      last_charge = now;
      return make_event(KIND_DISPATCH, run_id, run_left);
   endfunction

   // work out the scheduling events an item causes
   task automatic predict_schedule(req_type rq);
      rsp_type evs[$];
      logic [31:0] elapsed;
      int best;
      logic [15:0] old_id, old_left;
      case (rq.func)
         FUNC_ARRIVE: begin
            if (wait_ids.size() >= DEPTH) begin
               evs.push_back(make_event(KIND_DROPPED, rq.job_id, rq.job_time));
            end else begin
               wait_ids.push_back(rq.job_id);
               wait_times.push_back(rq.job_time);
               if (run_valid) begin
                  elapsed = rq.now - last_charge;
                  run_left = (elapsed >= {16'd0, run_left}) ? 16'd0
                             : run_left - elapsed[15:0];
                  last_charge = rq.now;
                  best = 0;
                  for (int i = 1; i < wait_times.size(); i++)
                     if (wait_times[i] < wait_times[best]) best = i;
                  if (wait_times[best] < run_left) begin
                     old_id = run_id;
                     old_left = run_left;
                     evs.push_back(make_event(KIND_PREEMPT, old_id, old_left));
                     evs.push_back(run_shortest(rq.now));
                     wait_ids.push_back(old_id);
                     wait_times.push_back(old_left);
                  end
               end else begin
                  evs.push_back(run_shortest(rq.now));
               end
            end
         end
         FUNC_FINISH: begin
            run_valid = 1'b0;
            if (wait_ids.size() == 0)
               evs.push_back(make_event(gen_done ? KIND_ALL_DONE : KIND_IDLE,
                                        16'd0, 16'd0));
            else
               evs.push_back(run_shortest(rq.now));
         end
         FUNC_SRC_DONE: gen_done = 1'b1;
         default: ;
      endcase
      if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      foreach (evs[i]) sched_events.push_back(evs[i]);
   endtask

   // result checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (rsp_data.kind == KIND_DROPPED) drops_seen <= drops_seen + 1;
         if (rsp_data.kind == KIND_PREEMPT) preempts_seen <= preempts_seen + 1;
         if (sched_events.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected result kind=%0d id=%0d time=%0d last=%0d",
                        rsp_data.kind, rsp_data.out_job_id,
                        rsp_data.out_job_time, rsp_data.last);
         end else begin
            if (rsp_data !== sched_events[0]) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display({"mismatch exp kind=%0d id=%0d time=%0d last=%0d,",
                            " got kind=%0d id=%0d time=%0d last=%0d"},
                           sched_events[0].kind, sched_events[0].out_job_id,
                           sched_events[0].out_job_time, sched_events[0].last,
                           rsp_data.kind, rsp_data.out_job_id,
                           rsp_data.out_job_time, rsp_data.last);
            end
            void'(sched_events.pop_front());
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", sched_events.size());
         $display("FAILURE");
         $finish;
      end
   end

   // one transfer on the command side
   task automatic send_item(req_type rq, bit with_gap);
      int gap;
      gap = with_gap ? int'($urandom_range(0, 4)) : 0;
      repeat (gap) @(posedge clock);
      req_data <= rq;
      start <= 1'b1;
      // busy is low here, so the transfer happens at this edge
      @(posedge clock);
      predict_schedule(rq);
      start <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [1:0] f, logic [31:0] now,
                                        logic [15:0] id, logic [15:0] t);
      req_type rq;
      rq.func = f;
      rq.now = now;
      rq.job_id = id;
      rq.job_time = t;
      return rq;
   endfunction

   task automatic drain_results();
      while (sched_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   typedef struct {
      req_type rq;
      bit checked;
      rsp_type fixed;
   } stim_row_type;

   logic [31:0] clock_now;

   initial begin
      stim_row_type rows[$];
      req_type rq;
      int pick;
      int waiting;
      mismatches = 0;
      results_seen = 0;
      drops_seen = 0;
      preempts_seen = 0;
      cycles = 0;
      run_valid = 1'b0;
      run_id = '0;
      run_left = '0;
      last_charge = '0;
      gen_done = 1'b0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; fixed results where they are obvious
      rows.push_back('{make_req(FUNC_FINISH, 32'd0, 16'd0, 16'd0), 1,
                       '{KIND_IDLE, 16'd0, 16'd0, 1'b1}});
      rows.push_back('{make_req(FUNC_ARRIVE, 32'd5, 16'hffff, 16'hffff), 1,
                       '{KIND_DISPATCH, 16'hffff, 16'hffff, 1'b1}});
      rows.push_back('{make_req(FUNC_ARRIVE, 32'd6, 16'd1, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_ARRIVE, 32'd7, 16'd2, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_ARRIVE, 32'd8, 16'd3, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_UNUSED, 32'hffffffff, 16'hffff, 16'hffff),
                       0, '0});
      rows.push_back('{make_req(FUNC_FINISH, 32'd9, 16'd0, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_ARRIVE, 32'hffffffff, 16'd4, 16'd100), 0,
                       '0});
      rows.push_back('{make_req(FUNC_ARRIVE, 32'd3, 16'd5, 16'd1), 0, '0});
      rows.push_back('{make_req(FUNC_FINISH, 32'd10, 16'd0, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_FINISH, 32'd11, 16'd0, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_FINISH, 32'd12, 16'd0, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_FINISH, 32'd13, 16'd0, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_SRC_DONE, 32'd14, 16'd0, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_FINISH, 32'd15, 16'd0, 16'd0), 0, '0});
      rows.push_back('{make_req(FUNC_FINISH, 32'd16, 16'd0, 16'd0), 1,
                       '{KIND_ALL_DONE, 16'd0, 16'd0, 1'b1}});
      foreach (rows[i]) begin
         if (rows[i].checked) begin
            predict_schedule(rows[i].rq);
            if (sched_events.size() == 0 || sched_events[$] !== rows[i].fixed) begin
               mismatches++;
               $display("directed row %0d: table and predictor disagree", i);
            end
            void'(sched_events.pop_back());
            sched_events.push_back(rows[i].fixed);
            // predictor state is already updated, only drive the item
            send_item_state_skip(rows[i].rq);
         end else begin
            send_item(rows[i].rq, 1'b1);
         end
      end
      drain_results();

      // fill the queue past full to reach drops, all with long times
      clock_now = 32'd100;
      for (int i = 0; i < DEPTH + 4; i++) begin
         clock_now += $urandom_range(0, 3);
         send_item(make_req(FUNC_ARRIVE, clock_now, 16'($urandom),
                            16'hff00 | 16'($urandom_range(0, 255))), i % 3 == 0);
      end
      // hold off until every result is in
      drain_results();

      // random mix of arrivals, completions, source done and unused codes
      for (int n = 0; n < 1100; n++) begin
         pick = $urandom_range(0, 99);
         waiting = wait_ids.size();
         if (pick < 2) clock_now = $urandom;
         else clock_now += $urandom_range(0, (pick < 10) ? 70000 : 40);
         if (pick < 3)
            rq = make_req(FUNC_UNUSED, clock_now, 16'($urandom), 16'($urandom));
         else if (pick < 5)
            rq = make_req(FUNC_SRC_DONE, clock_now, 16'($urandom), 16'($urandom));
         else if (pick < 50 - (waiting > 40 ? 15 : 0))
            rq = make_req(FUNC_ARRIVE, clock_now, 16'($urandom),
                          (pick & 1) ? 16'($urandom) : 16'($urandom_range(0, 60)));
         else
            rq = make_req(FUNC_FINISH, clock_now, 16'($urandom), 16'($urandom));
         if (n == 550) begin
            drain_results();
         end
         send_item(rq, n % 200 < 150);
      end

      drain_results();
      $display("covered %0d results, %0d preemptions and %0d dropped arrivals",
               results_seen, preempts_seen, drops_seen);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // send a directed row whose expectation was already queued
   task automatic send_item_state_skip(req_type rq);
      req_data <= rq;
      start <= 1'b1;
      @(posedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

endmodule
